// ===== src/stc_pkg.sv =====
`default_nettype none
package stc_pkg;

	typedef enum logic [2:0] {
		REQ_PRINT      = 3'd0,
		REQ_STORE      = 3'd1,
		REQ_PBUF_KEEP  = 3'd2,
		REQ_PBUF_FLUSH = 3'd3,
		REQ_FLUSH      = 3'd4,
		REQ_CLEAR      = 3'd5,
		REQ_REFRESH    = 3'd6,
		REQ_READ       = 3'd7
	} req_t;

	localparam logic KIND_GLYPH   = 1'b0;
	localparam logic KIND_REPAINT = 1'b1;

	localparam logic [7:0] NEWLINE   = 8'h0A;
	localparam logic [7:0] PRINT_LO  = 8'h20;
	localparam logic [7:0] PRINT_HI  = 8'h7E;
	localparam logic [5:0] MAX_RES   = 6'd44;

	typedef struct packed {
		logic       kind;
		logic [4:0] row;
		logic [5:0] col;
		logic [7:0] ch;
	} res_t;

endpackage
`default_nettype wire

// ===== src/stc_ram.sv =====
`default_nettype none
module stc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 40
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                     wdata,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== src/scrolling_text_console.sv =====
// Teletype text console with scroll.
// Input channel (in_valid/in_stall): one command per transfer: req_type,
// char_code, read_row, read_col. in_stall is high while a command is being
// worked; commands are taken one at a time.
// Output channel (out_valid/out_stall): result items out_kind, out_row,
// out_col, out_char; last marks the final item of a command. Commands with
// no result (flush, store into the buffer, non-printable bytes apart from a
// scrolling newline, empty buffer) give nothing on this channel.
// Printing the holding buffer takes, for each stored byte, a buffer RAM
// read and a line update, plus a repaint step when a printable byte scrolls
// the screen. Each result is held one step in a pending register
// so that last can be set; a stalled receiver stalls the command only once
// both the output and the pending register are full.
// Reset clears the screen (no lines), the scroll position and the buffer
// length; line and buffer RAM contents are not cleared.
`default_nettype none
module scrolling_text_console #(
	parameter int COLS = 40,
	parameter int ROWS = 25
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [2:0] req_type,
	input  wire  [7:0] char_code,
	input  wire  [4:0] read_row,
	input  wire  [5:0] read_col,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       out_kind,
	output logic [4:0] out_row,
	output logic [5:0] out_col,
	output logic [7:0] out_char,
	output logic       last
);
	import stc_pkg::*;

	localparam int CW  = $clog2(COLS + 1);
	localparam int HAW = $clog2(COLS);
	localparam int RW  = $clog2(ROWS);
	localparam int NW  = $clog2(ROWS + 1);
	localparam int SD  = ROWS * COLS;
	localparam int SAW = $clog2(SD);

	typedef enum logic [2:0] {ST_IDLE, ST_HRD, ST_PUT, ST_RP, ST_CELL, ST_FIN} state_t;
	typedef enum logic [1:0] {POST_NONE, POST_FLUSH, POST_PUT} post_t;

	state_t         state_q;
	post_t          post_q;
	logic [NW-1:0]  cnt_q;
	logic [RW-1:0]  top_q;
	logic [CW-1:0]  len_q [ROWS];
	logic [CW-1:0]  hlen_q;
	logic [HAW-1:0] hidx_q;
	logic           from_hold_q;
	logic [7:0]     ch_q;
	logic [4:0]     rrow_q;
	logic [5:0]     rcol_q;
	logic [5:0]     rcnt_q;
	res_t           pend_q, out_q;
	logic           pend_v_q, ov_q, olast_q;

	logic [7:0]     h_rdata, l_rdata, cur_ch;
	logic           printable, full_scr, put_open, go, em_v, em_fire, rd_hit, col_hit;
	logic           wrap, to_rp;
	logic [RW:0]    last_sum, open_sum, rd_sum;
	logic [RW-1:0]  last_slot, open_slot, rd_slot, top_next, lidx;
	logic [CW-1:0]  llen;
	logic [5:0]     put_row;
	logic [CW-1:0]  put_col;
	res_t           em_res;
	logic           l_we, h_we, ov_load;
	logic [SAW-1:0] l_waddr, l_raddr;

	// slot arithmetic: open_sum stays below 2*ROWS; last_sum and rd_sum can exceed it
	always_comb begin
		last_sum  = (RW+1)'(top_q) + (RW+1)'(cnt_q - NW'(1));
		last_slot = (last_sum >= (RW+1)'(ROWS)) ? RW'(last_sum - (RW+1)'(ROWS)) : RW'(last_sum);
		open_sum  = (RW+1)'(top_q) + (RW+1)'(cnt_q);
		full_scr  = cnt_q >= NW'(ROWS);
		open_slot = full_scr ? top_q :
			((open_sum >= (RW+1)'(ROWS)) ? RW'(open_sum - (RW+1)'(ROWS)) : RW'(open_sum));
		top_next  = (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
		rd_sum    = (RW+1)'(top_q) + (RW+1)'(read_row);
		rd_slot   = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : RW'(rd_sum);
		lidx      = (state_q == ST_IDLE) ? rd_slot : last_slot;
		llen      = len_q[lidx];
		rd_hit    = 6'(read_row) < 6'(cnt_q);
		col_hit   = 6'(read_col) < 6'(llen);
	end

	always_comb begin
		cur_ch    = from_hold_q ? h_rdata : ch_q;
		printable = (cur_ch >= PRINT_LO) && (cur_ch <= PRINT_HI);
		wrap      = (cnt_q != '0) && (llen >= CW'(COLS));
		put_open  = (printable && ((cnt_q == '0) || wrap)) ||
			((cur_ch == NEWLINE) && (cnt_q != '0));
		to_rp     = printable && put_open && full_scr;
		if (cnt_q == '0) begin
			put_row = '0;
		end else if (wrap) begin
			put_row = full_scr ? 6'(ROWS) : 6'(cnt_q);
		end else begin
			put_row = 6'(cnt_q) - 6'd1;
		end
		put_col = (cnt_q != '0 && !wrap) ? llen : '0;
	end

	always_comb begin
		em_v   = 1'b0;
		em_res = '{kind: KIND_REPAINT, row: '0, col: '0, ch: '0};
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_CLEAR || req_type == REQ_REFRESH) begin
						em_v = 1'b1;
					end else if (req_type == REQ_READ && !(rd_hit && col_hit)) begin
						em_v   = 1'b1;
						em_res = '{kind: KIND_GLYPH, row: read_row, col: read_col, ch: '0};
					end
				end
			end
			ST_PUT: begin
				if (printable) begin
					em_v   = 1'b1;
					em_res = '{kind: KIND_GLYPH, row: put_row[4:0], col: 6'(put_col), ch: cur_ch};
				end else if (cur_ch == NEWLINE && cnt_q != '0 && full_scr) begin
					em_v = 1'b1;
				end
			end
			ST_RP: em_v = 1'b1;
			ST_CELL: begin
				em_v   = 1'b1;
				em_res = '{kind: KIND_GLYPH, row: rrow_q, col: rcol_q, ch: l_rdata};
			end
			default: em_v = 1'b0;
		endcase
	end

	// pending result can only move on when the output register frees up
	assign go      = !pend_v_q || !ov_q || !out_stall;
	assign em_fire = em_v && go && (state_q == ST_IDLE || rcnt_q < MAX_RES);
	assign ov_load = (em_fire && pend_v_q) ||
		(state_q == ST_FIN && pend_v_q && (!ov_q || !out_stall));

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ov_q;
	assign out_kind  = out_q.kind;
	assign out_row   = out_q.row;
	assign out_col   = out_q.col;
	assign out_char  = out_q.ch;
	assign last      = olast_q;

	assign h_we    = (state_q == ST_IDLE) && in_valid && (req_type == REQ_STORE) &&
		(char_code != NEWLINE) && (hlen_q < CW'(COLS));
	assign l_we    = (state_q == ST_PUT) && go && printable;
	assign l_waddr = put_open ? SAW'(open_slot) * SAW'(COLS) :
		SAW'(last_slot) * SAW'(COLS) + SAW'(llen);
	assign l_raddr = SAW'(rd_slot) * SAW'(COLS) + SAW'(read_col);

	stc_ram #(.WIDTH(8), .DEPTH(COLS)) u_hold_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (HAW'(hlen_q)),
		.wdata (char_code),
		.raddr (hidx_q),
		.rdata (h_rdata)
	);

	stc_ram #(.WIDTH(8), .DEPTH(SD)) u_line_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (cur_ch),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			post_q      <= POST_NONE;
			cnt_q       <= '0;
			top_q       <= '0;
			for (int i = 0; i < ROWS; i++) begin
				len_q[i] <= '0;
			end
			hlen_q      <= '0;
			hidx_q      <= '0;
			from_hold_q <= 1'b0;
			ch_q        <= '0;
			rrow_q      <= '0;
			rcol_q      <= '0;
			rcnt_q      <= '0;
			pend_q      <= '0;
			out_q       <= '0;
			pend_v_q    <= 1'b0;
			ov_q        <= 1'b0;
			olast_q     <= 1'b0;
		end else begin
			if (ov_load) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			if (em_fire) begin
				if (pend_v_q) begin
					out_q   <= pend_q;
					olast_q <= 1'b0;
				end
				pend_q   <= em_res;
				pend_v_q <= 1'b1;
				if (state_q != ST_IDLE) begin
					rcnt_q <= rcnt_q + 6'd1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					rcnt_q <= em_fire ? 6'd1 : 6'd0;
					if (in_valid) begin
						case (req_type)
							REQ_PRINT: begin
								ch_q        <= char_code;
								from_hold_q <= 1'b0;
								post_q      <= POST_NONE;
								state_q     <= ST_PUT;
							end
							REQ_STORE: begin
								if (char_code == NEWLINE || hlen_q >= CW'(COLS)) begin
									ch_q    <= char_code;
									post_q  <= POST_PUT;
									hidx_q  <= '0;
									if (hlen_q != '0) begin
										from_hold_q <= 1'b1;
										state_q     <= ST_HRD;
									end else begin
										from_hold_q <= 1'b0;
										state_q     <= ST_PUT;
									end
								end else begin
									hlen_q <= hlen_q + CW'(1);
								end
							end
							REQ_PBUF_KEEP, REQ_PBUF_FLUSH: begin
								if (hlen_q != '0) begin
									from_hold_q <= 1'b1;
									hidx_q      <= '0;
									post_q      <= (req_type == REQ_PBUF_KEEP) ? POST_NONE : POST_FLUSH;
									state_q     <= ST_HRD;
								end
							end
							REQ_FLUSH: hlen_q <= '0;
							REQ_CLEAR: begin
								cnt_q <= '0;
								top_q <= '0;
								for (int i = 0; i < ROWS; i++) begin
									len_q[i] <= '0;
								end
								state_q <= ST_FIN;
							end
							REQ_REFRESH: state_q <= ST_FIN;
							default: begin
								rrow_q  <= read_row;
								rcol_q  <= read_col;
								state_q <= (rd_hit && col_hit) ? ST_CELL : ST_FIN;
							end
						endcase
					end
				end
				ST_HRD: state_q <= ST_PUT;
				ST_PUT, ST_RP: begin
					if (go) begin
						if (state_q == ST_PUT) begin
							if (put_open) begin
								len_q[open_slot] <= printable ? CW'(1) : '0;
								if (full_scr) begin
									top_q <= top_next;
								end else begin
									cnt_q <= cnt_q + NW'(1);
								end
							end else if (printable) begin
								len_q[last_slot] <= llen + CW'(1);
							end
						end
						if (state_q == ST_PUT && to_rp) begin
							state_q <= ST_RP;
						end else if (from_hold_q && (CW'(hidx_q) + CW'(1) != hlen_q)) begin
							hidx_q  <= hidx_q + HAW'(1);
							state_q <= ST_HRD;
						end else if (from_hold_q && post_q == POST_PUT) begin
							hlen_q      <= '0;
							from_hold_q <= 1'b0;
							state_q     <= ST_PUT;
						end else begin
							if (from_hold_q && post_q != POST_NONE) begin
								hlen_q <= '0;
							end
							from_hold_q <= 1'b0;
							state_q     <= ST_FIN;
						end
					end
				end
				ST_CELL: state_q <= ST_FIN;
				ST_FIN: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (!ov_q || !out_stall) begin
						out_q    <= pend_q;
						olast_q  <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q) else $error("pending result left in idle");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(ROWS)) else $error("line count beyond screen");
	a_hold_range: assert property (@(posedge clk) disable iff (!arst_n)
		hlen_q <= CW'(COLS)) else $error("buffer length beyond columns");
	a_repaint_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_q.kind == KIND_REPAINT |-> out_q.row == '0 && out_q.col == '0 &&
		out_q.ch == '0) else $error("repaint result carries data");
`endif

endmodule
`default_nettype wire
